// ===== rtl/iss_pkg.sv =====
// Shared types and constants of the image similarity score block.
`default_nettype none
package iss_pkg;

	localparam int PIX_W   = 8;
	localparam int LUMA_W  = 24;
	localparam int MEAS_W  = 24;
	localparam int SUM_W   = 48;
	localparam int SCORE_W = 17;
	localparam int COUNT_W = 17;
	localparam int MODE_W  = 2;

	localparam logic [MODE_W-1:0] MODE_COLOR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GRAY   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BINARY = 2'd2;

	// luma weights, Q0.16, they add up to exactly one
	localparam logic [15:0] W_B = 16'd7471;
	localparam logic [15:0] W_G = 16'd38470;
	localparam logic [15:0] W_R = 16'd19595;

	localparam logic [LUMA_W-1:0] LUMA_THRESH = 24'h80_0000;

	localparam int DIV_STEPS = 17;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_LOAD,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_div;
		logic prep_div;
		logic div_step;
	} iss_cmd_t;

	function automatic logic [PIX_W-1:0] absdiff8(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [LUMA_W-1:0] luma(input logic [PIX_W-1:0] b0,
			input logic [PIX_W-1:0] b1, input logic [PIX_W-1:0] b2);
		return LUMA_W'(W_B) * LUMA_W'(b0) + LUMA_W'(W_G) * LUMA_W'(b1)
			+ LUMA_W'(W_R) * LUMA_W'(b2);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/iss_pixel_if.sv =====
// Pixel pair channel: valid, ready and one candidate/target BGRA word.
`default_nettype none
interface iss_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] target_blue;
	logic [7:0] target_green;
	logic [7:0] target_red;
	logic [7:0] target_alpha;
	logic [7:0] cand_blue;
	logic [7:0] cand_green;
	logic [7:0] cand_red;
	logic [7:0] cand_alpha;
	logic       last_pixel;

	modport source (
		output valid, target_blue, target_green, target_red, target_alpha,
			cand_blue, cand_green, cand_red, cand_alpha, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, target_blue, target_green, target_red, target_alpha,
			cand_blue, cand_green, cand_red, cand_alpha, last_pixel,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/iss_result_if.sv =====
// Result channel: valid, ready, one score word, the total measure and the pixel count.
`default_nettype none
interface iss_result_if;
	logic        valid;
	logic        ready;
	logic [16:0] score_q16;
	logic [47:0] total_measure;
	logic [16:0] pixel_count;

	modport source (
		output valid, score_q16, total_measure, pixel_count,
		input  ready
	);
	modport sink (
		input  valid, score_q16, total_measure, pixel_count,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/iss_ctrl.sv =====
// Controller: accumulate phase, divider sequencing and result hold.
`default_nettype none
module iss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	input  logic              out_ready,
	output logic              in_ready,
	output logic              out_valid,
	output iss_pkg::iss_cmd_t cmd
);

	iss_pkg::state_t                state_q, state_d;
	logic [iss_pkg::STEP_W-1:0]     step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iss_pkg::ST_ACCUM;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		step_d    = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			iss_pkg::ST_ACCUM: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && in_last) begin
					state_d = iss_pkg::ST_LOAD;
				end
			end
			iss_pkg::ST_LOAD: begin
				cmd.load_div = 1'b1;
				state_d      = iss_pkg::ST_PREP;
			end
			iss_pkg::ST_PREP: begin
				cmd.prep_div = 1'b1;
				state_d      = iss_pkg::ST_DIV;
			end
			iss_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == iss_pkg::STEP_W'(iss_pkg::DIV_STEPS - 1)) begin
					step_d  = '0;
					state_d = iss_pkg::ST_DONE;
				end
			end
			iss_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = iss_pkg::ST_ACCUM;
				end
			end
			default: begin
				state_d = iss_pkg::ST_ACCUM;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/iss_datapath.sv =====
// Datapath: per-pixel measure, running sums, denominator and restoring divider.
`default_nettype none
module iss_datapath #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [iss_pkg::MODE_W-1:0]     cfg_wdata,
	input  iss_pkg::iss_cmd_t              cmd,
	input  logic [iss_pkg::PIX_W-1:0]      target_blue,
	input  logic [iss_pkg::PIX_W-1:0]      target_green,
	input  logic [iss_pkg::PIX_W-1:0]      target_red,
	input  logic [iss_pkg::PIX_W-1:0]      target_alpha,
	input  logic [iss_pkg::PIX_W-1:0]      cand_blue,
	input  logic [iss_pkg::PIX_W-1:0]      cand_green,
	input  logic [iss_pkg::PIX_W-1:0]      cand_red,
	input  logic [iss_pkg::PIX_W-1:0]      cand_alpha,
	input  logic                           last_pixel,
	output logic [iss_pkg::SCORE_W-1:0]    score_q16,
	output logic [iss_pkg::SUM_W-1:0]      total_measure,
	output logic [iss_pkg::COUNT_W-1:0]    pixel_count
);

	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int DW    = CNT_W + 24;
	localparam int CW    = (DW > iss_pkg::SUM_W) ? DW : iss_pkg::SUM_W;

	logic [iss_pkg::MODE_W-1:0]  mode_q;
	logic [iss_pkg::MODE_W-1:0]  score_mode_q;
	logic [iss_pkg::SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]            count_q;
	logic [iss_pkg::SUM_W-1:0]   total_q;
	logic [CNT_W-1:0]            n_q;
	logic [DW-1:0]               d_q;
	logic [DW:0]                 rem_q;
	logic [iss_pkg::SCORE_W-1:0] quo_q;

	logic [iss_pkg::LUMA_W-1:0]  luma_t, luma_c;
	logic [iss_pkg::MEAS_W-1:0]  meas;
	logic                        full;
	logic [iss_pkg::SUM_W-1:0]   sum_next;
	logic [CNT_W-1:0]            count_next;
	logic [DW-1:0]               n_ext;
	logic [DW-1:0]               d_next;
	logic                        score_binary;
	logic                        tot_ge_d;
	logic [CW-1:0]               d_minus_t;
	logic [DW-1:0]               rem_init;
	logic                        rem_ge;
	logic [DW:0]                 rem_sub;

	assign luma_t = iss_pkg::luma(target_blue, target_green, target_red);
	assign luma_c = iss_pkg::luma(cand_blue, cand_green, cand_red);

	always_comb begin
		unique case (mode_q)
			iss_pkg::MODE_COLOR: begin
				meas = iss_pkg::MEAS_W'(iss_pkg::absdiff8(target_blue, cand_blue))
					+ iss_pkg::MEAS_W'(iss_pkg::absdiff8(target_green, cand_green))
					+ iss_pkg::MEAS_W'(iss_pkg::absdiff8(target_red, cand_red))
					+ iss_pkg::MEAS_W'(iss_pkg::absdiff8(target_alpha, cand_alpha));
			end
			iss_pkg::MODE_GRAY: begin
				meas = (luma_t >= luma_c) ? luma_t - luma_c : luma_c - luma_t;
			end
			default: begin
				meas = iss_pkg::MEAS_W'((luma_t > iss_pkg::LUMA_THRESH)
					== (luma_c > iss_pkg::LUMA_THRESH));
			end
		endcase
	end

	assign full       = (count_q == CNT_W'(MAX_PIXELS));
	assign sum_next   = full ? sum_q : sum_q + iss_pkg::SUM_W'(meas);
	assign count_next = full ? count_q : count_q + 1'b1;

	// denominator from shifts: 1020n, 255n << 16, or n
	assign n_ext = DW'(n_q);
	always_comb begin
		unique case (score_mode_q)
			iss_pkg::MODE_COLOR: d_next = (n_ext << 10) - (n_ext << 2);
			iss_pkg::MODE_GRAY:  d_next = ((n_ext << 8) - n_ext) << 16;
			default:             d_next = n_ext;
		endcase
	end

	assign score_binary = !(score_mode_q == iss_pkg::MODE_COLOR
		|| score_mode_q == iss_pkg::MODE_GRAY);
	assign tot_ge_d  = CW'(total_q) >= CW'(d_q);
	assign d_minus_t = CW'(d_q) - CW'(total_q);

	// dividend is always at most the divisor, so the quotient fits 17 bits
	always_comb begin
		if (score_binary) begin
			rem_init = tot_ge_d ? d_q : DW'(total_q);
		end else begin
			rem_init = tot_ge_d ? '0 : DW'(d_minus_t);
		end
	end

	assign rem_ge  = rem_q >= {1'b0, d_q};
	assign rem_sub = rem_q - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= iss_pkg::MODE_COLOR;
			sum_q   <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				if (last_pixel) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= sum_next;
					count_q <= count_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && last_pixel) begin
			total_q      <= sum_next;
			n_q          <= count_next;
			score_mode_q <= mode_q;
		end
		if (cmd.load_div) begin
			d_q <= d_next;
		end
		if (cmd.prep_div) begin
			rem_q <= {1'b0, rem_init};
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[iss_pkg::SCORE_W-2:0], rem_ge};
			rem_q <= (rem_ge ? rem_sub : rem_q) << 1;
		end
	end

	assign score_q16     = quo_q;
	assign total_measure = total_q;
	assign pixel_count   = iss_pkg::COUNT_W'(n_q);

endmodule
`default_nettype wire

// ===== rtl/image_similarity_score_top.sv =====
// Top level of the image similarity score block.
// Scores a candidate BGRA image against a target, one pixel pair per word on
// in_ch. Pixels that are not last are taken one per cycle. The last pixel
// starts the score: the denominator is formed, then the dividend, then the
// one-bit-per-cycle restoring divider forms the 17-bit quotient, and the
// result word is then held on out_ch until accepted; no pixel is taken from
// the last pixel until the result word leaves. metric_mode (cfg_wdata on
// cfg_we) selects color, gray or binary scoring and must be written only
// while the block is idle; the block itself does not enforce this.
`default_nettype none
module image_similarity_score_top #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [iss_pkg::MODE_W-1:0] cfg_wdata,
	iss_pixel_if.sink                  in_ch,
	iss_result_if.source               out_ch
);

	iss_pkg::iss_cmd_t cmd;

	iss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last_pixel),
		.out_ready (out_ch.ready),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	iss_datapath #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.target_blue   (in_ch.target_blue),
		.target_green  (in_ch.target_green),
		.target_red    (in_ch.target_red),
		.target_alpha  (in_ch.target_alpha),
		.cand_blue     (in_ch.cand_blue),
		.cand_green    (in_ch.cand_green),
		.cand_red      (in_ch.cand_red),
		.cand_alpha    (in_ch.cand_alpha),
		.last_pixel    (in_ch.last_pixel),
		.score_q16     (out_ch.score_q16),
		.total_measure (out_ch.total_measure),
		.pixel_count   (out_ch.pixel_count)
	);

`ifndef ASSERT_OFF
	a_no_input_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input ready while result pending");

	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.last_pixel) |=> !in_ch.ready && !out_ch.valid)
		else $error("input not stalled after last pixel");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.score_q16 <= 17'd65536))
		else $error("score above one");
`endif

endmodule
`default_nettype wire
